// ===== hw/rtl/wcp_pkg.sv =====
// wcp_pkg: types, tags and constants shared by the WAV cue chunk parser.
// No dependencies; every other file of the block refers to it by scoped names.
package wcp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_CUE  = 32'h2065_7563;

  localparam logic [4:0]  CUE_POINT_BYTES   = 5'd24;
  localparam logic [4:0]  CHUNK_HDR_BYTES   = 5'd8;
  localparam logic [4:0]  CUE_COUNT_BYTES   = 5'd4;
  localparam logic [32:0] FILE_HEADER_BYTES = 33'd12;

  typedef enum logic [3:0] {
    PH_HEADER    = 4'd0,
    PH_CHUNK_HDR = 4'd1,
    PH_SKIP      = 4'd2,
    PH_COUNT     = 4'd3,
    PH_POINT     = 4'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [31:0] cue_offset;
    logic        offset_valid;
    logic        finished;
    logic        success;
  } out_item_t;

  // result request from the parse core to the output buffer
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } push_t;

endpackage

// ===== hw/rtl/wcp_parse_core.sv =====
// wcp_parse_core: parse state registers, file length register and the
// per-byte next-state and result logic. Depends on wcp_pkg.
module wcp_parse_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  wcp_pkg::in_item_t item,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_value,
  output wcp_pkg::push_t    push
);

  logic [31:0]          file_length_r;
  logic [32:0]          byte_position_r, byte_position_nxt;
  wcp_pkg::phase_t      parse_phase_r, parse_phase_nxt;
  logic [63:0]          field_shift_r, field_shift_nxt;
  logic [32:0]          chunk_end_r, chunk_end_nxt;
  logic                 pad_pending_r, pad_pending_nxt;
  logic [31:0]          cues_total_r, cues_total_nxt;
  logic [31:0]          cues_done_r, cues_done_nxt;
  logic [4:0]           cue_byte_index_r, cue_byte_index_nxt;
  logic                 parse_over_r, parse_over_nxt;

  // state as seen after an optional restart by file_start
  logic [32:0]          cur_pos;
  wcp_pkg::phase_t      cur_phase;
  logic [63:0]          cur_shift;
  logic [32:0]          cur_chunk_end;
  logic                 cur_pad;
  logic [31:0]          cur_total;
  logic [31:0]          cur_done;
  logic [4:0]           cur_idx;
  logic                 cur_over;

  logic                 active;
  logic [32:0]          pos1;
  logic [63:0]          shift_new;
  logic [31:0]          hi;
  logic [31:0]          id;
  logic [4:0]           idx_inc;
  logic                 boundary_fail;
  logic [32:0]          ce_new;
  logic [33:0]          endpad_new;
  logic [33:0]          endpad_r;
  logic                 hdr_last;
  logic                 hdr_over;
  logic                 is_cue;
  logic                 cue_small;
  logic                 skip_done_new;
  logic                 skip_done_r;
  logic                 cnt_last;
  logic [37:0]          cnt_limit;
  logic                 cnt_bad;
  logic                 pt_last;
  logic [31:0]          done_inc;
  logic                 all_done;
  wcp_pkg::out_item_t   res;
  logic                 res_valid;

  always_comb begin
    if (item.file_start) begin
      cur_pos       = '0;
      cur_phase     = wcp_pkg::PH_HEADER;
      cur_shift     = '0;
      cur_chunk_end = '0;
      cur_pad       = 1'b0;
      cur_total     = '0;
      cur_done      = '0;
      cur_idx       = '0;
      cur_over      = 1'b0;
    end else begin
      cur_pos       = byte_position_r;
      cur_phase     = parse_phase_r;
      cur_shift     = field_shift_r;
      cur_chunk_end = chunk_end_r;
      cur_pad       = pad_pending_r;
      cur_total     = cues_total_r;
      cur_done      = cues_done_r;
      cur_idx       = cue_byte_index_r;
      cur_over      = parse_over_r;
    end
  end

  assign active    = ~cur_over;
  assign pos1      = cur_pos + 33'd1;
  assign shift_new = {item.data_byte, cur_shift[63:8]};
  assign hi        = shift_new[63:32];
  assign id        = shift_new[31:0];
  assign idx_inc   = cur_idx + 5'd1;

  assign boundary_fail = ({1'b0, pos1} + 34'd8) > {2'b00, file_length_r};

  assign ce_new        = pos1 + {1'b0, hi};
  assign endpad_new    = {1'b0, ce_new} + {33'd0, hi[0]};
  assign endpad_r      = {1'b0, cur_chunk_end} + {33'd0, cur_pad};
  assign hdr_last      = idx_inc >= wcp_pkg::CHUNK_HDR_BYTES;
  assign hdr_over      = endpad_new > {2'b00, file_length_r};
  assign is_cue        = id == wcp_pkg::TAG_CUE;
  assign cue_small     = hi < 32'd4;
  assign skip_done_new = {1'b0, pos1} >= endpad_new;
  assign skip_done_r   = {1'b0, pos1} >= endpad_r;

  // floor(room / 24) < count  <=>  chunk_end < pos1 + 24 * count
  assign cnt_last  = idx_inc >= wcp_pkg::CUE_COUNT_BYTES;
  assign cnt_limit = {5'd0, pos1} + {2'b00, hi, 4'd0} + {3'b000, hi, 3'd0};
  assign cnt_bad   = (hi != 32'd0) && ({5'd0, cur_chunk_end} < cnt_limit);

  assign pt_last  = idx_inc >= wcp_pkg::CUE_POINT_BYTES;
  assign done_inc = cur_done + 32'd1;
  assign all_done = done_inc >= cur_total;

  // result of this byte
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    if (active) begin
      case (cur_phase)
        wcp_pkg::PH_HEADER: begin
          if ((cur_pos == 33'd0) && ({1'b0, file_length_r} < wcp_pkg::FILE_HEADER_BYTES)) begin
            res_valid = 1'b1;
          end else if ((cur_pos == 33'd3) && (hi != wcp_pkg::TAG_RIFF)) begin
            res_valid = 1'b1;
          end else if (cur_pos == wcp_pkg::FILE_HEADER_BYTES - 33'd1) begin
            res_valid = (hi != wcp_pkg::TAG_WAVE) || boundary_fail;
          end
        end
        wcp_pkg::PH_CHUNK_HDR: begin
          if (hdr_last) begin
            if (hdr_over) begin
              res_valid = 1'b1;
            end else if (is_cue) begin
              res_valid = cue_small;
            end else begin
              res_valid = skip_done_new && boundary_fail;
            end
          end
        end
        wcp_pkg::PH_SKIP: begin
          res_valid = skip_done_r && boundary_fail;
        end
        wcp_pkg::PH_COUNT: begin
          if (cnt_last) begin
            if (cnt_bad) begin
              res_valid = 1'b1;
            end else if (hi == 32'd0) begin
              res_valid   = 1'b1;
              res.success = 1'b1;
            end
          end
        end
        wcp_pkg::PH_POINT: begin
          if (pt_last) begin
            res_valid        = 1'b1;
            res.cue_offset   = hi;
            res.offset_valid = 1'b1;
            res.success      = all_done;
          end
        end
        default: begin
          res_valid = 1'b1;
        end
      endcase
      // every result but a non-final cue point ends the file
      res.finished = res_valid && !(res.offset_valid && !res.success);
    end
  end

  assign push.valid = step && res_valid;
  assign push.item  = res;

  // next state
  always_comb begin
    byte_position_nxt  = cur_pos;
    parse_phase_nxt    = cur_phase;
    field_shift_nxt    = cur_shift;
    chunk_end_nxt      = cur_chunk_end;
    pad_pending_nxt    = cur_pad;
    cues_total_nxt     = cur_total;
    cues_done_nxt      = cur_done;
    cue_byte_index_nxt = cur_idx;
    parse_over_nxt     = cur_over | res.finished;
    if (active) begin
      byte_position_nxt = pos1;
      field_shift_nxt   = shift_new;
      case (cur_phase)
        wcp_pkg::PH_HEADER: begin
          if (cur_pos == wcp_pkg::FILE_HEADER_BYTES - 33'd1) begin
            parse_phase_nxt    = wcp_pkg::PH_CHUNK_HDR;
            cue_byte_index_nxt = '0;
          end
        end
        wcp_pkg::PH_CHUNK_HDR: begin
          cue_byte_index_nxt = idx_inc;
          if (hdr_last) begin
            cue_byte_index_nxt = '0;
            chunk_end_nxt      = ce_new;
            pad_pending_nxt    = hi[0];
            if (is_cue) begin
              parse_phase_nxt = wcp_pkg::PH_COUNT;
            end else if (skip_done_new) begin
              parse_phase_nxt = wcp_pkg::PH_CHUNK_HDR;
            end else begin
              parse_phase_nxt = wcp_pkg::PH_SKIP;
            end
          end
        end
        wcp_pkg::PH_SKIP: begin
          if (skip_done_r) begin
            parse_phase_nxt    = wcp_pkg::PH_CHUNK_HDR;
            cue_byte_index_nxt = '0;
          end
        end
        wcp_pkg::PH_COUNT: begin
          cue_byte_index_nxt = idx_inc;
          if (cnt_last) begin
            cue_byte_index_nxt = '0;
            cues_total_nxt     = hi;
            cues_done_nxt      = '0;
            if (hi != 32'd0) begin
              parse_phase_nxt = wcp_pkg::PH_POINT;
            end
          end
        end
        wcp_pkg::PH_POINT: begin
          cue_byte_index_nxt = idx_inc;
          if (pt_last) begin
            cue_byte_index_nxt = '0;
            cues_done_nxt      = done_inc;
          end
        end
        default: begin
          parse_phase_nxt = cur_phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_length_r <= '0;
    end else if (cfg_we) begin
      file_length_r <= cfg_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_position_r  <= '0;
      parse_phase_r    <= wcp_pkg::PH_HEADER;
      field_shift_r    <= '0;
      chunk_end_r      <= '0;
      pad_pending_r    <= 1'b0;
      cues_total_r     <= '0;
      cues_done_r      <= '0;
      cue_byte_index_r <= '0;
      parse_over_r     <= 1'b0;
    end else if (step) begin
      byte_position_r  <= byte_position_nxt;
      parse_phase_r    <= parse_phase_nxt;
      field_shift_r    <= field_shift_nxt;
      chunk_end_r      <= chunk_end_nxt;
      pad_pending_r    <= pad_pending_nxt;
      cues_total_r     <= cues_total_nxt;
      cues_done_r      <= cues_done_nxt;
      cue_byte_index_r <= cue_byte_index_nxt;
      parse_over_r     <= parse_over_nxt;
    end
  end

endmodule

// ===== hw/rtl/wcp_out_buf.sv =====
// wcp_out_buf: result register plus one skid entry, so bytes keep flowing
// while a result waits downstream. Depends on wcp_pkg.
module wcp_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  wcp_pkg::push_t     push,
  output logic               can_take,
  output logic               out_valid,
  input  logic               out_ready,
  output wcp_pkg::out_item_t out_data
);

  logic               main_v_r, main_v_nxt;
  logic               skid_v_r, skid_v_nxt;
  wcp_pkg::out_item_t main_r, main_nxt;
  wcp_pkg::out_item_t skid_r, skid_nxt;
  logic               pop;

  assign pop       = main_v_r && out_ready;
  assign can_take  = ~skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  // push never arrives while the skid entry is full
  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (pop) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push.valid) begin
      if (!main_v_r || pop) begin
        main_nxt   = push.item;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push.item;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ===== hw/rtl/wav_cue_chunk_parser_unit.sv =====
// wav_cue_chunk_parser_unit: top level of the WAV cue chunk parser.
// Instantiates wcp_parse_core and wcp_out_buf; types from wcp_pkg.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+---------------------------------
//   in      | in  | in_valid / in_ready   | in_data  (data_byte, file_start)
//   out     | out | out_valid / out_ready | out_data (cue_offset, flags)
//   cfg     | in  | cfg_valid / cfg_ready | cfg_data (file_length)
//
// One byte per cycle while in_ready is high; a result is registered in
// the output register, or in its skid entry while that one is still held.
// Synchronous active-low reset clears the parse state and file_length;
// the parser then sits at byte 0 of a file. in_ready drops only while the
// output register and its skid entry are both full. cfg_ready is always high.
module wav_cue_chunk_parser_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  wcp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output wcp_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);

  wcp_pkg::push_t push;
  logic           step;

  assign cfg_ready = 1'b1;
  assign step      = in_valid && in_ready;

  wcp_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (in_data),
    .cfg_we    (cfg_valid),
    .cfg_value (cfg_data),
    .push      (push)
  );

  wcp_out_buf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .can_take  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/wcp_checker.sv =====
// wcp_checker: port-level assertions for wav_cue_chunk_parser_unit, bound
// to the top level below. Depends on wcp_pkg.
module wcp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input wcp_pkg::out_item_t out_data,
  input logic               cfg_ready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a non-final result is always a cue point
  a_mid_is_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.finished || out_data.offset_valid))
    else $error("non-final result without offset");

  // success only comes with finished; offset zero when not carried
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.finished || !out_data.success) &&
                   (out_data.offset_valid || (out_data.cue_offset == 32'd0))))
    else $error("inconsistent result flags");

  // input may stall only with a result waiting
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && cfg_ready)
    else $error("input stalled with empty output");

endmodule

bind wav_cue_chunk_parser_unit wcp_checker u_wcp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .cfg_ready (cfg_ready)
);
